/* rtl/pfba_pkg.sv */
// Shared types, codes and defaults of the page frame bump allocator.
// Used by pfba_ctrl, pfba_dp and page_frame_bump_allocator; depends on nothing.
`default_nettype none

package pfba_pkg;

   localparam int DEF_MAX_REGIONS = 16;
   localparam int DEF_PAGE_BYTES  = 4096;

   localparam int CSR_IDX_W = 2;

   // Request codes
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_ALLOC  = 2'd1;
   localparam logic [1:0] REQ_ADDR   = 2'd2;
   localparam logic [1:0] REQ_NUMBER = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RSV_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RSV_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGIONS   = 2'd2;

   // Largest page number handed out, and the top of the address space
   localparam logic [32:0] NUM_LIMIT = 33'h0_FFFF_FFFE;
   localparam logic [32:0] SPACE_TOP = 33'h1_0000_0000;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  region_index;
      logic [31:0] region_start;
      logic [31:0] region_size;
      logic        region_is_reserved;
      logic [31:0] query_value;
   } pfba_req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        found;
   } pfba_rsp_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic eval_size;
      logic eval_hit;
      logic judge;
      logic finish;
   } pfba_cmd_type;

   typedef struct packed {
      logic empty;
      logic stop;
   } pfba_status_type;

endpackage

`default_nettype wire

/* rtl/pfba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module pfba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/pfba_ctrl.sv */
// Sequencer of the page frame bump allocator: walks the region table in
// three phases per region. Depends on pfba_pkg.
`default_nettype none

module pfba_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_is_load,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output pfba_pkg::pfba_cmd_type         cmd,
   input  wire pfba_pkg::pfba_status_type status
);
   import pfba_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SIZE  = 3'd1;
   localparam logic [2:0] ST_HIT   = 3'd2;
   localparam logic [2:0] ST_JUDGE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_is_load) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SIZE;
               end
            end
         end
         ST_SIZE: begin
            // skip the walk when nothing can match
            if (status.empty) begin
               state_in = ST_DONE;
            end else begin
               cmd.eval_size = 1'b1;
               state_in      = ST_HIT;
            end
         end
         ST_HIT: begin
            cmd.eval_hit = 1'b1;
            state_in     = ST_JUDGE;
         end
         ST_JUDGE: begin
            cmd.judge = 1'b1;
            state_in  = status.stop ? ST_DONE : ST_SIZE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/pfba_dp.sv */
// Datapath of the page frame bump allocator: region table, configuration
// registers, page arithmetic and result register. Depends on pfba_pkg, pfba_ram.
`default_nettype none

module pfba_dp #(
   parameter int MAX_REGIONS = pfba_pkg::DEF_MAX_REGIONS,
   parameter int PAGE_BYTES  = pfba_pkg::DEF_PAGE_BYTES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pfba_pkg::pfba_cmd_type            cmd,
   output pfba_pkg::pfba_status_type              status,
   input  wire pfba_pkg::pfba_req_type            req_data,
   input  wire logic                              csr_valid,
   input  wire logic [pfba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [31:0]                       csr_data,
   output pfba_pkg::pfba_rsp_type                 rsp_data
);
   import pfba_pkg::*;

   localparam int SHIFT   = $clog2(PAGE_BYTES);
   localparam int ADDR_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
   localparam int ENTRY_W = 65;

   // Configuration
   logic [31:0]    rsv_start_ff, rsv_start_in;
   logic [31:0]    rsv_end_ff, rsv_end_in;
   logic [4:0]     regions_ff, regions_in;

   // Walk state
   logic [1:0]       kind_ff, kind_in;
   logic [31:0]      query_ff, query_in;
   logic [32:0]      want_ff, want_in;
   logic [CNT_W-1:0] slot_ff, slot_in;
   logic [32:0]      before_ff, before_in;
   logic [32:0]      pages_ff, pages_in;
   logic [32:0]      k0_ff, k0_in;
   logic [32:0]      k1_ff, k1_in;
   logic             inside_ff, inside_in;
   logic [32:0]      nv_ff, nv_in;
   logic             res_found_ff, res_found_in;
   logic [31:0]      res_value_ff, res_value_in;
   logic [31:0]      next_frame_ff, next_frame_in;
   pfba_rsp_type     rsp_data_ff, rsp_data_in;

   // Table
   logic               wr_en;
   logic [ENTRY_W-1:0] rd_entry;
   logic [31:0]        base;
   logic [31:0]        len;
   logic               rsv;

   logic [CNT_W-1:0] used;
   logic [32:0]      base33;
   logic [32:0]      first_num;
   logic [32:0]      sum_end, end_clip, span, lo;
   logic [32:0]      page_addr, k_past, region_top, q33;
   logic             hit, skip, hdr_valid, last;
   logic             is_num, take, over;
   logic [32:0]      cand;
   logic [31:0]      page_out, value;

   assign wr_en = cmd.load && (32'(req_data.region_index) < 32'(MAX_REGIONS));

   pfba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_data.region_index)),
      .wr_data ({req_data.region_is_reserved, req_data.region_size,
                 req_data.region_start}),
      .rd_addr (slot_in[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   assign base   = rd_entry[31:0];
   assign len    = rd_entry[63:32];
   assign rsv    = rd_entry[64];
   assign base33 = {1'b0, base};
   assign q33    = {1'b0, query_ff};

   // Slots in use, clamped to the table depth
   assign used = ({27'd0, regions_ff} > 32'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS)
                                                          : CNT_W'(regions_ff);
   assign last = ((CNT_W + 1)'(slot_ff) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(used);

   assign first_num = before_ff + 33'd1;
   assign skip      = (kind_ff == REQ_ALLOC);
   assign is_num    = (kind_ff == REQ_NUMBER);
   assign hdr_valid = (rsv_start_ff <= rsv_end_ff);

   // Size phase: whole pages below the top of the address space
   assign sum_end  = base33 + {1'b0, len};
   assign end_clip = sum_end[32] ? SPACE_TOP : sum_end;
   assign span     = end_clip - base33;
   assign lo       = (want_ff > first_num) ? want_ff : first_num;

   // Hit phase: header range test on the candidate page
   assign page_addr  = base33 + (k0_ff << SHIFT);
   assign hit        = skip && hdr_valid && (k0_ff < pages_ff) &&
                       (page_addr >= {1'b0, rsv_start_ff}) &&
                       (page_addr <= {1'b0, rsv_end_ff});
   assign k_past     = (({1'b0, rsv_end_ff} - base33) >> SHIFT) + 33'd1;
   assign region_top = base33 + (pages_ff << SHIFT);

   // Judge phase
   assign take     = is_num ? inside_ff : (!rsv && (k1_ff < pages_ff));
   assign cand     = is_num ? nv_ff : (first_num + k1_ff);
   assign over     = (cand > NUM_LIMIT);
   assign page_out = 32'(base33 + (k1_ff << SHIFT));
   assign value    = (kind_ff == REQ_ADDR) ? page_out : cand[31:0];

   assign status.empty = (used == '0) || (!skip && (query_ff == 32'd0));
   assign status.stop  = take || last;

   always_comb begin
      rsv_start_in = rsv_start_ff;
      rsv_end_in   = rsv_end_ff;
      regions_in   = regions_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RSV_START: rsv_start_in = csr_data;
            CSR_RSV_END:   rsv_end_in   = csr_data;
            CSR_REGIONS:   regions_in   = csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      kind_in       = kind_ff;
      query_in      = query_ff;
      want_in       = want_ff;
      slot_in       = slot_ff;
      before_in     = before_ff;
      pages_in      = pages_ff;
      k0_in         = k0_ff;
      k1_in         = k1_ff;
      inside_in     = inside_ff;
      nv_in         = nv_ff;
      res_found_in  = res_found_ff;
      res_value_in  = res_value_ff;
      next_frame_in = next_frame_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.capture) begin
         kind_in      = req_data.req_type;
         query_in     = req_data.query_value;
         want_in      = (req_data.req_type == REQ_ALLOC) ? {1'b0, next_frame_ff}
                                                         : {1'b0, req_data.query_value};
         slot_in      = '0;
         before_in    = '0;
         res_found_in = 1'b0;
         res_value_in = '0;
      end
      if (cmd.eval_size) begin
         pages_in = span >> SHIFT;
         k0_in    = lo - first_num;
      end
      if (cmd.eval_hit) begin
         // move past the header range when the candidate page lands in it
         k1_in     = hit ? k_past : k0_ff;
         inside_in = (q33 >= base33) && (q33 < region_top);
         nv_in     = first_num + ((q33 - base33) >> SHIFT);
      end
      if (cmd.judge) begin
         if (take && !over) begin
            res_found_in = 1'b1;
            res_value_in = value;
         end
         before_in = before_ff + pages_ff;
         slot_in   = slot_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_data_in.result_value = res_value_ff;
         rsp_data_in.found        = res_found_ff;
         if (skip && res_found_ff) begin
            next_frame_in = res_value_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsv_start_ff  <= '0;
         rsv_end_ff    <= '0;
         regions_ff    <= '0;
         next_frame_ff <= 32'd1;
         slot_ff       <= '0;
      end else begin
         rsv_start_ff  <= rsv_start_in;
         rsv_end_ff    <= rsv_end_in;
         regions_ff    <= regions_in;
         next_frame_ff <= next_frame_in;
         slot_ff       <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      query_ff     <= query_in;
      want_ff      <= want_in;
      before_ff    <= before_in;
      pages_ff     <= pages_in;
      k0_ff        <= k0_in;
      k1_ff        <= k1_in;
      inside_ff    <= inside_in;
      nv_ff        <= nv_in;
      res_found_ff <= res_found_in;
      res_value_ff <= res_value_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/page_frame_bump_allocator.sv */
// Page frame bump allocator: a load transaction gives no response; a query or allocation
// walks the regions in use through the region table RAM in a three-phase step per region
// and stops at the first hit or the last slot; with no slot in use or a zero lookup it
// skips the walk. A response not yet taken holds the next one back.
// The response sits in an output register, so the next transaction is taken meanwhile.
// Synchronous active-high reset clears control, configuration and sets next frame to 1;
// region table contents are undefined until loaded.
// Depends on pfba_pkg, pfba_ctrl, pfba_dp (which holds pfba_ram).
`default_nettype none

module page_frame_bump_allocator #(
   parameter int MAX_REGIONS = pfba_pkg::DEF_MAX_REGIONS,
   parameter int PAGE_BYTES  = pfba_pkg::DEF_PAGE_BYTES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire pfba_pkg::pfba_req_type         req_data,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output pfba_pkg::pfba_rsp_type              rsp_data,
   // configuration write channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [pfba_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_data
);
   import pfba_pkg::*;

   pfba_cmd_type    cmd;
   pfba_status_type status;

   // Configuration writes land at once; software must only write while idle, which the block itself does not enforce.
   assign csr_ready = 1'b1;

   // Sequencer: accept a transaction, step the walk, hand off to the output register.
   pfba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_load (req_data.req_type == REQ_LOAD),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .status      (status)
   );

   // Datapath: region table, page arithmetic, next-frame counter, result register.
   pfba_dp #(
      .MAX_REGIONS (MAX_REGIONS),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
